FILE: design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and codes shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int GRANULE_BYTES = 8;
  localparam int GRAN_SHIFT    = 3;
  localparam int LEN_W         = 12;
  localparam int OFF_W         = 14;
  localparam int REQ_W         = 15;
  localparam int NEED_W        = 13;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_NO_POOL = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_offset;
    logic [1:0]       status;
  } out_item_t;

  typedef struct packed {
    logic             free;
    logic [LEN_W-1:0] len;
  } blk_t;

endpackage

FILE: design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a pool of 8-byte granules; block headers live in
// one single-port-write, registered-read memory walked by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     start, busy, in_item           taken when start & !busy
//  result    out_valid, out_item            one-cycle strobe, never stalled
//  config    cfg_we, cfg_wdata              written when cfg_we
//
//  after the accept cycle, allocate reads each block header up to the fitting
//  one, with a further mark step for a split; free reads its own header, the
//  next one when it lies in the pool, then each header walked from the pool
//  start when the freed block is not the first; init and early exits add nothing
//  the result strobe follows the last work cycle; busy is high in between
//  reset clears control state only; header memory is undefined until init
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int POOL_BYTES = 16384
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ffba_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ffba_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [11:0]         cfg_wdata
);

  localparam int MAX_G = POOL_BYTES / ffba_pkg::GRANULE_BYTES;
  localparam int GW    = $clog2(MAX_G);
  localparam int SW    = ((GW > ffba_pkg::LEN_W) ? GW : ffba_pkg::LEN_W) + 1;
  localparam int LW    = ffba_pkg::LEN_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_A_RD  = 10'b0000000010,
    S_A_CHK = 10'b0000000100,
    S_A_MRK = 10'b0000001000,
    S_F_RDH = 10'b0000010000,
    S_F_H   = 10'b0000100000,
    S_F_RDN = 10'b0001000000,
    S_F_N   = 10'b0010000000,
    S_F_RDC = 10'b0100000000,
    S_F_C   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] walk_r, walk_nxt;
  logic [SW-1:0] hdr_r, hdr_nxt;
  logic [SW-1:0] pool_len_r, pool_len_nxt;
  logic [ffba_pkg::NEED_W-1:0] need_r, need_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] pool_gran_r;
  logic          ready_r, ready_nxt;
  logic          out_valid_r;
  ffba_pkg::out_item_t out_item_r;

  ffba_pkg::blk_t mem [MAX_G];
  ffba_pkg::blk_t mem_q_r;
  logic [GW-1:0]  rd_addr;
  logic           wr_en;
  logic [GW-1:0]  wr_addr;
  ffba_pkg::blk_t wr_data;

  logic                finish;
  ffba_pkg::out_item_t fin_item;

  logic [15:0]                 req_sum;
  logic [ffba_pkg::NEED_W-1:0] need_calc;
  logic [SW-1:0]               need_ext;
  logic [SW-1:0]               clamp_len;
  logic [10:0]                 gran;
  logic [SW-1:0]               hdr_calc;
  logic [SW-1:0]               q_len_ext;
  logic [SW-1:0]               walk_len;
  logic [SW-1:0]               walk_need;
  logic [SW-1:0]               walk_inc;
  logic [LW-1:0]               split_len;
  logic [LW-1:0]               merge_len;
  logic [ffba_pkg::OFF_W-1:0]  alloc_off;

  assign req_sum   = {1'b0, in_item.request_bytes} + 16'd15;
  assign need_calc = req_sum[15:ffba_pkg::GRAN_SHIFT];
  assign need_ext  = SW'(need_calc);
  assign gran      = in_item.payload_offset[ffba_pkg::OFF_W-1:ffba_pkg::GRAN_SHIFT];
  assign hdr_calc  = SW'(gran) - SW'(1);
  assign q_len_ext = SW'(mem_q_r.len);
  assign walk_len  = walk_r + q_len_ext;
  assign walk_need = walk_r + SW'(need_r);
  assign walk_inc  = walk_r + SW'(1);
  assign split_len = mem_q_r.len - need_r[LW-1:0];
  assign merge_len = mem_q_r.len + len_r;
  assign alloc_off = {walk_inc[10:0], 3'b000};

  always_comb begin
    if (pool_gran_r < LW'(2)) begin
      clamp_len = SW'(2);
    end else if (SW'(pool_gran_r) > SW'(MAX_G)) begin
      clamp_len = SW'(MAX_G);
    end else begin
      clamp_len = SW'(pool_gran_r);
    end
  end

  always_comb begin
    case (state_r)
      S_F_RDH: rd_addr = hdr_r[GW-1:0];
      default: rd_addr = walk_r[GW-1:0];
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    walk_nxt     = walk_r;
    hdr_nxt      = hdr_r;
    pool_len_nxt = pool_len_r;
    need_nxt     = need_r;
    len_nxt      = len_r;
    ready_nxt    = ready_r;
    wr_en        = 1'b0;
    wr_addr      = walk_r[GW-1:0];
    wr_data      = mem_q_r;
    finish       = 1'b0;
    fin_item     = '{result_offset: '0, status: ffba_pkg::ST_DONE};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.operation)
            ffba_pkg::OP_INIT: begin
              pool_len_nxt = clamp_len;
              ready_nxt    = 1'b1;
              wr_en        = 1'b1;
              wr_addr      = '0;
              wr_data      = '{free: 1'b1, len: clamp_len[LW-1:0]};
              finish       = 1'b1;
            end
            ffba_pkg::OP_ALLOC: begin
              need_nxt = need_calc;
              walk_nxt = '0;
              if (!ready_r) begin
                finish          = 1'b1;
                fin_item.status = ffba_pkg::ST_NO_POOL;
              end else if (need_ext > pool_len_r) begin
                finish          = 1'b1;
                fin_item.status = ffba_pkg::ST_NO_FIT;
              end else begin
                state_nxt = S_A_RD;
              end
            end
            ffba_pkg::OP_FREE: begin
              hdr_nxt = hdr_calc;
              if (!ready_r) begin
                finish          = 1'b1;
                fin_item.status = ffba_pkg::ST_NO_POOL;
              end else if (gran == '0 || hdr_calc >= pool_len_r) begin
                finish = 1'b1;
              end else begin
                state_nxt = S_F_RDH;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_A_RD: begin
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (mem_q_r.len == '0) begin
          finish          = 1'b1;
          fin_item.status = ffba_pkg::ST_NO_FIT;
        end else if (mem_q_r.free && q_len_ext >= SW'(need_r)) begin
          if (split_len >= LW'(2) && walk_need < SW'(MAX_G)) begin
            wr_en     = 1'b1;
            wr_addr   = walk_need[GW-1:0];
            wr_data   = '{free: 1'b1, len: split_len};
            state_nxt = S_A_MRK;
          end else begin
            wr_en                  = 1'b1;
            wr_data                = '{free: 1'b0, len: mem_q_r.len};
            finish                 = 1'b1;
            fin_item.result_offset = alloc_off;
          end
        end else begin
          walk_nxt = walk_len;
          if (walk_len < pool_len_r) begin
            state_nxt = S_A_RD;
          end else begin
            finish          = 1'b1;
            fin_item.status = ffba_pkg::ST_NO_FIT;
          end
        end
      end
      S_A_MRK: begin
        wr_en                  = 1'b1;
        wr_data                = '{free: 1'b0, len: need_r[LW-1:0]};
        finish                 = 1'b1;
        fin_item.result_offset = alloc_off;
      end
      S_F_RDH: begin
        state_nxt = S_F_H;
      end
      S_F_H: begin
        wr_en   = 1'b1;
        wr_addr = hdr_r[GW-1:0];
        wr_data = '{free: 1'b1, len: mem_q_r.len};
        len_nxt = mem_q_r.len;
        if (hdr_r + q_len_ext < pool_len_r) begin
          walk_nxt  = hdr_r + q_len_ext;
          state_nxt = S_F_RDN;
        end else begin
          walk_nxt = '0;
          if (hdr_r != '0) begin
            state_nxt = S_F_RDC;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_F_RDN: begin
        state_nxt = S_F_N;
      end
      S_F_N: begin
        if (mem_q_r.free) begin
          wr_en   = 1'b1;
          wr_addr = hdr_r[GW-1:0];
          wr_data = '{free: 1'b1, len: merge_len};
          len_nxt = merge_len;
        end
        walk_nxt = '0;
        if (hdr_r != '0) begin
          state_nxt = S_F_RDC;
        end else begin
          finish = 1'b1;
        end
      end
      S_F_RDC: begin
        state_nxt = S_F_C;
      end
      S_F_C: begin
        if (mem_q_r.len == '0) begin
          finish = 1'b1;
        end else if (walk_len == hdr_r && mem_q_r.free) begin
          wr_en   = 1'b1;
          wr_data = '{free: 1'b1, len: merge_len};
          finish  = 1'b1;
        end else begin
          walk_nxt = walk_len;
          if (walk_len < hdr_r) begin
            state_nxt = S_F_RDC;
          end else begin
            finish = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      pool_len_r  <= '0;
      pool_gran_r <= 12'd2048;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      pool_len_r  <= pool_len_nxt;
      out_valid_r <= finish;
      if (cfg_we) begin
        pool_gran_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    hdr_r  <= hdr_nxt;
    need_r <= need_nxt;
    len_r  <= len_nxt;
    if (finish) begin
      out_item_r <= fin_item;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE)
    else $error("result strobe while sequencer busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither in work nor finished");

  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_RD || state_r == S_F_RDN || state_r == S_F_RDC)
      |-> walk_r < SW'(MAX_G))
    else $error("header walk left the pool");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ffba_pkg::ST_DONE) |-> out_item.result_offset == '0)
    else $error("failed item carries an offset");

  a_pool_len: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (pool_len_r >= SW'(2) && pool_len_r <= SW'(MAX_G)))
    else $error("latched pool length out of range");
`endif

endmodule
